// File: rtl/sync_frame_field_extractor_macros.svh
// assertion macros for the frame extractor checker
`ifndef SYNC_FRAME_FIELD_EXTRACTOR_MACROS_SVH
`define SYNC_FRAME_FIELD_EXTRACTOR_MACROS_SVH

// clocked assertion, off while reset is asserted
`define SFFE_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, checked on every edge
`define SFFE_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/sffe_pkg.sv
// constants and register codes of the frame field extractor
`timescale 1ns / 1ps
package sffe_pkg;

    localparam int NUM_VALUES    = 10;
    localparam int OUT_VALUES    = 10;
    localparam int PAYLOAD_BYTES = 2 * NUM_VALUES;
    localparam int STORE_DEPTH   = PAYLOAD_BYTES - 1;

    localparam logic [7:0] SYNC_FIRST  = 8'hFE;
    localparam logic [7:0] SYNC_SECOND = 8'h19;

    localparam int PH_DATA_I = 6;
    localparam int PHASE_W   = $clog2(PH_DATA_I + PAYLOAD_BYTES);

    localparam logic [PHASE_W-1:0] PH_HUNT   = PHASE_W'(0);
    localparam logic [PHASE_W-1:0] PH_SYNC2  = PHASE_W'(1);
    localparam logic [PHASE_W-1:0] PH_ID_LO  = PHASE_W'(2);
    localparam logic [PHASE_W-1:0] PH_ID_HI  = PHASE_W'(3);
    localparam logic [PHASE_W-1:0] PH_LEN_LO = PHASE_W'(4);
    localparam logic [PHASE_W-1:0] PH_LEN_HI = PHASE_W'(5);
    localparam logic [PHASE_W-1:0] PH_DATA   = PHASE_W'(PH_DATA_I);

    localparam logic [7:0] MESSAGE_ID_RST = 8'd5;
    localparam logic [7:0] HUNT_LIMIT_RST = 8'd110;

    typedef enum logic {
        REG_MESSAGE_ID = 1'b0,
        REG_HUNT_LIMIT = 1'b1
    } t_reg_idx;

    localparam logic KIND_FRAME   = 1'b0;
    localparam logic KIND_TIMEOUT = 1'b1;

    typedef logic [15:0] t_value;

endpackage

// File: rtl/sffe_in_if.sv
// byte input channel
`timescale 1ns / 1ps
interface sffe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
    modport mon    (input valid, input rx_byte, input ready);
endinterface

// File: rtl/sffe_out_if.sv
// result channel: decoded frame values or hunt timeout
`timescale 1ns / 1ps
interface sffe_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] right_x;
    logic [15:0] right_y;
    logic [15:0] left_y;
    logic [15:0] left_x;
    logic [15:0] switch_a;
    logic [15:0] switch_b;
    logic [15:0] switch_c;
    logic [15:0] switch_d;
    logic [15:0] knob_a;
    logic [15:0] knob_b;
    logic        error_seen;

    modport source (
        output valid, output kind, output right_x, output right_y, output left_y,
        output left_x, output switch_a, output switch_b, output switch_c,
        output switch_d, output knob_a, output knob_b, output error_seen,
        input ready
    );
    modport sink (
        input valid, input kind, input right_x, input right_y, input left_y,
        input left_x, input switch_a, input switch_b, input switch_c,
        input switch_d, input knob_a, input knob_b, input error_seen,
        output ready
    );
    modport mon (
        input valid, input kind, input right_x, input right_y, input left_y,
        input left_x, input switch_a, input switch_b, input switch_c,
        input switch_d, input knob_a, input knob_b, input error_seen,
        input ready
    );
endinterface

// File: rtl/sync_frame_field_extractor.sv
// Frame field extractor: parses a received byte stream into frames of ten values.
// One byte is taken every clock cycle; a byte accepted at one edge has its result (if any)
// in the output register from the next cycle on, and the next byte is taken in the same
// cycle as long as the output register is empty or being drained. The byte parser is a
// single state register plus a 19-byte payload store in flip-flops, all updated at the
// accept edge; the result register is what parts the input and output handshakes. A
// frame result appears on the byte that completes the payload; a hunt timeout result
// (all values zero, error_seen set) appears when the non-sync count reaches hunt_limit.
// The user writes message_id and hunt_limit via the config port only while idle; unenforced.
`timescale 1ns / 1ps
module sync_frame_field_extractor
    import sffe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    sffe_in_if.sink     i_in,
    sffe_out_if.source  o_out
);

    logic [7:0]         r_message_id;
    logic [7:0]         r_hunt_limit;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [7:0]         r_hunt_count, n_hunt_count;
    logic               r_error, n_error;
    logic [7:0]         r_field [STORE_DEPTH];

    logic               r_out_valid;
    logic               r_kind;
    logic               r_err_seen;
    t_value             r_val [OUT_VALUES];

    t_value             w_val [OUT_VALUES];
    logic               w_accept;
    logic               w_emit;
    logic               w_emit_kind;
    logic               w_store;
    logic [PHASE_W-1:0] w_pos;
    logic [7:0]         w_byte;
    logic [7:0]         w_cnt_inc;
    logic               w_hunt;

    assign w_byte   = i_in.rx_byte;
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept = i_in.valid && i_in.ready;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_message_id <= MESSAGE_ID_RST;
            r_hunt_limit <= HUNT_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_MESSAGE_ID: r_message_id <= i_cfg_data;
                REG_HUNT_LIMIT: r_hunt_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_pos     = r_phase - PH_DATA;
    assign w_cnt_inc = r_hunt_count + 8'd1;

    // parser next state
    always_comb begin
        n_phase      = r_phase;
        n_hunt_count = r_hunt_count;
        n_error      = r_error;
        w_emit       = 1'b0;
        w_emit_kind  = KIND_FRAME;
        w_store      = 1'b0;
        w_hunt       = 1'b0;

        if (r_phase == PH_HUNT) begin
            w_hunt = 1'b1;
        end else if (r_phase == PH_SYNC2) begin
            if (w_byte == SYNC_SECOND) n_phase = PH_ID_LO;
            else w_hunt = 1'b1;
        end else if (r_phase == PH_ID_LO) begin
            n_phase = PH_ID_HI;
        end else if (r_phase == PH_ID_HI) begin
            if (w_byte == r_message_id) n_phase = PH_LEN_LO;
            else w_hunt = 1'b1;
        end else if (r_phase == PH_LEN_LO) begin
            n_phase = PH_LEN_HI;
        end else if (r_phase == PH_LEN_HI) begin
            n_phase = PH_DATA;
        end else if (w_pos < PHASE_W'(STORE_DEPTH)) begin
            w_store = 1'b1;
            n_phase = r_phase + PHASE_W'(1);
        end else if (w_pos == PHASE_W'(STORE_DEPTH)) begin
            // last payload byte closes the frame
            w_emit  = 1'b1;
            n_phase = PH_HUNT;
        end else begin
            n_phase = PH_HUNT;
        end

        // a failed check falls back to hunting on the same byte
        if (w_hunt) begin
            if (w_byte == SYNC_FIRST) begin
                n_hunt_count = 8'd0;
                n_phase      = PH_SYNC2;
            end else begin
                n_phase = PH_HUNT;
                if (w_cnt_inc >= r_hunt_limit) begin
                    n_hunt_count = 8'd0;
                    n_error      = 1'b1;
                    w_emit       = 1'b1;
                    w_emit_kind  = KIND_TIMEOUT;
                end else begin
                    n_hunt_count = w_cnt_inc;
                end
            end
        end
    end

    // assemble little-endian values; the last high byte is the incoming byte
    for (genvar k = 0; k < OUT_VALUES; k++) begin : g_val
        if (k < NUM_VALUES) begin : g_used
            if (2 * k + 1 < STORE_DEPTH) begin : g_stored
                assign w_val[k] = {r_field[2*k+1], r_field[2*k]};
            end else begin : g_last
                assign w_val[k] = {w_byte, r_field[2*k]};
            end
        end else begin : g_unused
            assign w_val[k] = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_hunt_count <= 8'd0;
            r_error      <= 1'b0;
        end else if (w_accept) begin
            r_phase      <= n_phase;
            r_hunt_count <= n_hunt_count;
            r_error      <= n_error;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
            if (w_accept && w_store && w_pos == PHASE_W'(i)) begin
                r_field[i] <= w_byte;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= w_emit;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit) begin
            r_kind     <= w_emit_kind;
            r_err_seen <= (w_emit_kind == KIND_TIMEOUT) ? 1'b1 : r_error;
            for (int k = 0; k < OUT_VALUES; k++) begin
                r_val[k] <= (w_emit_kind == KIND_TIMEOUT) ? 16'd0 : w_val[k];
            end
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.kind       = r_kind;
    assign o_out.right_x    = r_val[0];
    assign o_out.right_y    = r_val[1];
    assign o_out.left_y     = r_val[2];
    assign o_out.left_x     = r_val[3];
    assign o_out.switch_a   = r_val[4];
    assign o_out.switch_b   = r_val[5];
    assign o_out.switch_c   = r_val[6];
    assign o_out.switch_d   = r_val[7];
    assign o_out.knob_a     = r_val[8];
    assign o_out.knob_b     = r_val[9];
    assign o_out.error_seen = r_err_seen;

endmodule

// File: rtl/sffe_checker.sv
// port-level checker for the frame field extractor, bound to the top level
`timescale 1ns / 1ps
`include "sync_frame_field_extractor_macros.svh"
module sffe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    sffe_in_if.sink    i_in,
    sffe_out_if.source o_out
);

    // stalled word holds
    `SFFE_ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.kind) && $stable(o_out.error_seen) && $stable(o_out.right_x), "result changed while stalled")

    // empty result register never blocks input
    `SFFE_ASSERT_RST(a_ready_empty, i_clk, i_rst_n, !o_out.valid |-> i_in.ready, "input stalled with empty output")

    // timeout word carries zero values and the error flag
    `SFFE_ASSERT_RST(a_timeout_word, i_clk, i_rst_n, o_out.valid && o_out.kind |-> o_out.error_seen && o_out.right_x == 16'd0 && o_out.left_x == 16'd0 && o_out.knob_b == 16'd0, "bad timeout word")

    // error flag is sticky across results
    `SFFE_ASSERT_RST(a_error_sticky, i_clk, i_rst_n, o_out.valid && o_out.ready && o_out.error_seen |=> !o_out.valid || o_out.error_seen, "error flag dropped")

endmodule

bind sync_frame_field_extractor sffe_checker u_sffe_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_in    (i_in),
    .o_out   (o_out)
);

// File: test/sffe_frame_checker.sv
// scoreboard for the frame field extractor: tracks the parser state and checks every result word
`timescale 1ns / 1ps
module sffe_frame_checker
    import sffe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    sffe_in_if.mon      i_in,
    sffe_out_if.mon     i_out,
    output int          o_errors,
    output int          o_pending
);

    typedef struct {
        logic   kind;
        t_value vals [OUT_VALUES];
        logic   error_seen;
    } t_frame;

    localparam int REPORT_MAX = 10;

    string value_names [OUT_VALUES] = '{
        "right_x", "right_y", "left_y", "left_x", "switch_a",
        "switch_b", "switch_c", "switch_d", "knob_a", "knob_b"
    };

    logic [7:0]         id_reg;
    logic [7:0]         limit_reg;
    logic [PHASE_W-1:0] parse_phase;
    logic [7:0]         hunt_cnt;
    logic [7:0]         payload [STORE_DEPTH];
    logic               err_sticky;
    t_frame             due_results [$];
    int                 fail_cnt = 0;

    assign o_errors = fail_cnt;

    task automatic report(input string what);
        fail_cnt++;
        if (fail_cnt <= REPORT_MAX) begin
            $display("%0t: %s", $realtime, what);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            report($sformatf("mismatch on %s: expected %h, got %h", name, want, got));
        end
    endtask

    // byte seen while hunting, or a byte that failed a header check
    task automatic hunt_step(input logic [7:0] b);
        t_frame res;
        if (b == SYNC_FIRST) begin
            hunt_cnt    = '0;
            parse_phase = PH_SYNC2;
        end else begin
            parse_phase = PH_HUNT;
            hunt_cnt    = hunt_cnt + 8'd1;
            if (hunt_cnt >= limit_reg) begin
                hunt_cnt   = '0;
                err_sticky = 1'b1;
                res.kind   = KIND_TIMEOUT;
                foreach (res.vals[k]) res.vals[k] = '0;
                res.error_seen = 1'b1;
                due_results.push_back(res);
            end
        end
    endtask

    always @(posedge i_clk) begin : track
        t_frame     got;
        t_frame     want;
        t_frame     res;
        int         pos;
        logic [7:0] b;
        logic [7:0] hi;
        if (!i_rst_n) begin
            id_reg      = MESSAGE_ID_RST;
            limit_reg   = HUNT_LIMIT_RST;
            parse_phase = PH_HUNT;
            hunt_cnt    = '0;
            err_sticky  = 1'b0;
            due_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MESSAGE_ID: id_reg = i_cfg_data;
                    REG_HUNT_LIMIT: limit_reg = i_cfg_data;
                endcase
            end

            // output side first: a byte taken at this edge cannot have its result out yet
            if (i_out.valid && i_out.ready) begin
                got.kind       = i_out.kind;
                got.vals[0]    = i_out.right_x;
                got.vals[1]    = i_out.right_y;
                got.vals[2]    = i_out.left_y;
                got.vals[3]    = i_out.left_x;
                got.vals[4]    = i_out.switch_a;
                got.vals[5]    = i_out.switch_b;
                got.vals[6]    = i_out.switch_c;
                got.vals[7]    = i_out.switch_d;
                got.vals[8]    = i_out.knob_a;
                got.vals[9]    = i_out.knob_b;
                got.error_seen = i_out.error_seen;
                if (due_results.size() == 0) begin
                    report($sformatf("result word with nothing expected, kind %0d", got.kind));
                end else begin
                    want = due_results.pop_front();
                    check_field("kind", want.kind, got.kind);
                    for (int k = 0; k < OUT_VALUES; k++) begin
                        check_field(value_names[k], want.vals[k], got.vals[k]);
                    end
                    check_field("error_seen", want.error_seen, got.error_seen);
                end
            end

            if (i_in.valid && i_in.ready) begin
                b = i_in.rx_byte;
                case (parse_phase)
                    PH_HUNT: hunt_step(b);
                    PH_SYNC2: begin
                        if (b == SYNC_SECOND) parse_phase = PH_ID_LO;
                        else hunt_step(b);
                    end
                    PH_ID_LO: parse_phase = PH_ID_HI;
                    PH_ID_HI: begin
                        if (b == id_reg) parse_phase = PH_LEN_LO;
                        else hunt_step(b);
                    end
                    PH_LEN_LO: parse_phase = PH_LEN_HI;
                    PH_LEN_HI: parse_phase = PH_DATA;
                    default: begin
                        pos = int'(parse_phase) - PH_DATA_I;
                        if (pos < STORE_DEPTH) begin
                            payload[pos] = b;
                            parse_phase  = parse_phase + 1'b1;
                        end else begin
                            if (pos == STORE_DEPTH) begin
                                // last payload byte goes straight into the top value
                                res.kind = KIND_FRAME;
                                for (int k = 0; k < OUT_VALUES; k++) begin
                                    if (k < NUM_VALUES) begin
                                        hi = (2 * k + 1 < STORE_DEPTH) ? payload[2 * k + 1] : b;
                                        res.vals[k] = {hi, payload[2 * k]};
                                    end else begin
                                        res.vals[k] = '0;
                                    end
                                end
                                res.error_seen = err_sticky;
                                due_results.push_back(res);
                            end
                            parse_phase = PH_HUNT;
                        end
                    end
                endcase
            end
        end
        o_pending <= due_results.size();
    end

endmodule

// File: test/tb_sync_frame_field_extractor.sv
// testbench top for the frame field extractor: byte stimulus, register phases and verdict
`timescale 1ns / 1ps
module tb_sync_frame_field_extractor;
    import sffe_pkg::*;

    localparam int N_PHASES        = 6;
    localparam int ITEMS_PER_PHASE = 135;
    localparam int RX_HOLD_AFTER   = 200;
    localparam int RX_HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT  = 3000;

    // failed second sync byte, resync inside the header, id byte that is itself a sync,
    // wrong id, then a full frame on the reset id with extreme and sync-like payload bytes
    localparam logic [7:0] OPENING [36] = '{
        8'hFE, 8'h00,
        8'hFE, 8'hFE, 8'h19, 8'h00, 8'hFE, 8'h19, 8'h00, 8'h06,
        8'hFE, 8'h19, 8'hFF, 8'h05, 8'h00, 8'hFF,
        8'hFF, 8'hFF, 8'h00, 8'h00, 8'h01, 8'h80, 8'hFE, 8'h19, 8'h7F, 8'hFE,
        8'h55, 8'hAA, 8'hFE, 8'hFE, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h12, 8'hFE
    };

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_idx;
    logic [7:0] cfg_data;
    int         errors;
    int         pending;
    int         sent_cnt = 0;
    int         quiet_cycles = 0;
    bit         tx_tight = 1'b0;
    logic [7:0] cur_id;
    logic [7:0] cur_limit;

    sffe_in_if  in_ch ();
    sffe_out_if out_ch ();

    sync_frame_field_extractor dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    sffe_frame_checker frame_check (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .i_out      (out_ch),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_sync_frame_field_extractor NOT OK");
            $finish;
        end
    end

    // mostly back to back, sometimes a few cycles, rarely a long pause
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        if (r == 2) return SYNC_FIRST;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_tight ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= b;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sent_cnt++;
    endtask

    task automatic send_frame(input logic [7:0] id_hi, input int n_data);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(rand_byte());
        send_byte(id_hi);
        send_byte(rand_byte());
        send_byte(rand_byte());
        repeat (n_data) send_byte(rand_byte());
    endtask

    task automatic run_sequence();
        int         r;
        int         n;
        logic [7:0] b;
        tx_tight = ($urandom_range(0, 99) < 12);
        r = $urandom_range(0, 99);
        if (r < 62) begin
            send_frame(cur_id, PAYLOAD_BYTES);
        end else if (r < 70) begin
            // sync followed by a wrong second byte, often another sync
            b = rand_byte();
            if (b == SYNC_SECOND || $urandom_range(0, 3) == 0) b = SYNC_FIRST;
            send_byte(SYNC_FIRST);
            send_byte(b);
        end else if (r < 78) begin
            b = rand_byte();
            if ($urandom_range(0, 3) == 0) b = SYNC_FIRST;
            if (b == cur_id) b = ~cur_id;
            send_byte(SYNC_FIRST);
            send_byte(SYNC_SECOND);
            send_byte(rand_byte());
            send_byte(b);
        end else if (r < 85) begin
            // cut frame: whatever follows is taken as payload
            send_frame(cur_id, $urandom_range(0, PAYLOAD_BYTES - 1));
        end else begin
            n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8)
                                           : $urandom_range(1, int'(cur_limit) + 4);
            repeat (n) begin
                b = 8'($urandom_range(0, 255));
                if (b == SYNC_FIRST && $urandom_range(0, 3) != 0) b = 8'h00;
                send_byte(b);
            end
        end
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] id_val, input logic [7:0] limit_val);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_MESSAGE_ID;
        cfg_data <= id_val;
        @(posedge clk);
        cfg_idx  <= REG_HUNT_LIMIT;
        cfg_data <= limit_val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_id    = id_val;
        cur_limit = limit_val;
    endtask

    // result side: random stalls plus one long hold-off once traffic is under way
    initial begin
        int gap;
        int run;
        bit held;
        held         = 1'b0;
        out_ch.ready = 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            if (!held && sent_cnt >= RX_HOLD_AFTER) begin
                held = 1'b1;
                repeat (RX_HOLD_CYCLES) begin
                    @(posedge clk);
                    out_ch.ready <= 1'b0;
                end
            end
            gap = pick_gap();
            repeat (gap) begin
                @(posedge clk);
                out_ch.ready <= 1'b0;
            end
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
            repeat (run) begin
                @(posedge clk);
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [7:0] next_id;
        logic [7:0] next_limit;
        int         phase_end;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = REG_MESSAGE_ID;
        cfg_data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.rx_byte = '0;
        cur_id        = MESSAGE_ID_RST;
        cur_limit     = HUNT_LIMIT_RST;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < $size(OPENING); i++) send_byte(OPENING[i]);

        for (int p = 0; p < N_PHASES; p++) begin
            if (p > 0) begin
                wait_idle();
                case (p)
                    1: begin
                        next_id    = 8'h00;
                        next_limit = 8'd1;
                    end
                    2: begin
                        next_id    = 8'hFF;
                        next_limit = 8'd255;
                    end
                    3: begin
                        next_id    = SYNC_FIRST;
                        next_limit = 8'd2;
                    end
                    4: begin
                        next_id    = SYNC_SECOND;
                        next_limit = 8'($urandom_range(3, 40));
                    end
                    default: begin
                        next_id    = 8'($urandom_range(0, 255));
                        next_limit = 8'($urandom_range(1, 255));
                    end
                endcase
                set_config(next_id, next_limit);
            end
            phase_end = sent_cnt + ITEMS_PER_PHASE;
            while (sent_cnt < phase_end) run_sequence();
        end

        wait_idle();
        if (errors == 0 && pending == 0) begin
            $display("tb_sync_frame_field_extractor OK");
        end else begin
            $display("tb_sync_frame_field_extractor NOT OK");
        end
        $finish;
    end

endmodule
